/* rtl/btr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_pkg: shared types and constants of the bitmap font text rasterizer
// Item record between front end and back end, state encoding, register map.
// ----------------------------------------------------------------------------
package btr_pkg;

    // field widths
    localparam int ROW_W    = 3;
    localparam int BITS_W   = 8;
    localparam int CODE_W   = 8;
    localparam int SLOT_W   = 8;
    localparam int ORIGIN_W = 12;
    localparam int COORD_W  = 13;
    localparam int LINE_W   = 12;
    localparam int ADDR_W   = 32;
    localparam int PROD_W   = 26;

    // font slot holds eight rows whatever the glyph height
    localparam int ROWS_PER_SLOT = 8;

    // character codes
    localparam logic [CODE_W-1:0] FIRST_CODE   = 8'h20;
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;

    // blank space between glyphs and between lines
    localparam int GAP = 2;

    // operation codes of an input item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // configuration register map
    localparam int   CFG_IDX_W        = 1;
    localparam int   CFG_DATA_W       = 32;
    localparam logic REG_SCREEN_WIDTH = 1'b0;
    localparam logic REG_FRAME_BASE   = 1'b1;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST = 13'd800;
    localparam logic [ADDR_W-1:0]  FRAME_BASE_RST   = 32'h0000_0000;

    // item queue, depth a power of two so the pointers wrap
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic [2:0] {
        ITEM_LOAD,
        ITEM_SKIP,
        ITEM_NEWLINE,
        ITEM_BLANK,
        ITEM_GLYPH
    } item_kind_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [SLOT_W-1:0]   glyph;
        logic [ROW_W-1:0]    row;
        logic [BITS_W-1:0]   bits;
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic                first;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_FETCH,
        ST_BASE,
        ST_COL,
        ST_FLUSH
    } back_state_t;

    typedef struct packed {
        logic idle;
        logic hold_valid;
        logic halted;
    } back_status_t;

endpackage

/* rtl/btr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 768
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/btr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_front: input item decoder
// Sorts each input item into load, ignored load, newline, blank or glyph.
// ----------------------------------------------------------------------------
module btr_front #(
    parameter int GLYPH_COUNT = 96
) (
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [6:0]                      s_glyph_index,
    input  logic [btr_pkg::ROW_W-1:0]       s_glyph_row,
    input  logic [btr_pkg::BITS_W-1:0]      s_glyph_row_bits,
    input  logic [btr_pkg::CODE_W-1:0]      s_char_code,
    input  logic [btr_pkg::ORIGIN_W-1:0]    s_origin_x,
    input  logic [btr_pkg::ORIGIN_W-1:0]    s_origin_y,
    input  logic                            s_first_of_string,
    output logic                            push_valid,
    output btr_pkg::item_t                  push_item,
    input  logic                            push_ready
);

    localparam logic [8:0] COUNT9 = 9'(GLYPH_COUNT);

    logic [8:0] code_off;
    logic       code_in_font;
    logic       load_in_font;

    // offset of the character code into the font
    assign code_off     = {1'b0, s_char_code} - {1'b0, btr_pkg::FIRST_CODE};
    assign code_in_font = (s_char_code >= btr_pkg::FIRST_CODE) && (code_off < COUNT9);
    assign load_in_font = {2'b00, s_glyph_index} < COUNT9;

    // item classification
    always_comb begin
        push_item          = '0;
        push_item.row      = s_glyph_row;
        push_item.bits     = s_glyph_row_bits;
        push_item.origin_x = s_origin_x;
        push_item.origin_y = s_origin_y;
        push_item.first    = s_first_of_string;
        if (s_operation == btr_pkg::OP_LOAD) begin
            push_item.glyph = {1'b0, s_glyph_index};
            push_item.kind  = load_in_font ? btr_pkg::ITEM_LOAD : btr_pkg::ITEM_SKIP;
        end else if (s_char_code == btr_pkg::NEWLINE_CODE) begin
            push_item.glyph = '0;
            push_item.kind  = btr_pkg::ITEM_NEWLINE;
        end else if (code_in_font) begin
            push_item.glyph = code_off[btr_pkg::SLOT_W-1:0];
            push_item.kind  = btr_pkg::ITEM_GLYPH;
        end else begin
            push_item.glyph = '0;
            push_item.kind  = btr_pkg::ITEM_BLANK;
        end
    end

    // input transfer goes straight into the queue
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

endmodule

/* rtl/btr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_queue: short item queue
// Decouples the decoder from the drawing engine so each can stall alone.
// ----------------------------------------------------------------------------
module btr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    input  btr_pkg::item_t push_item,
    output logic           push_ready,
    output logic           pop_valid,
    output btr_pkg::item_t pop_item,
    input  logic           pop_ready
);

    localparam logic [btr_pkg::Q_PTR_W:0] FULL_COUNT = (btr_pkg::Q_PTR_W + 1)'(btr_pkg::Q_DEPTH);

    btr_pkg::item_t                slot_reg [btr_pkg::Q_DEPTH];
    logic [btr_pkg::Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [btr_pkg::Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [btr_pkg::Q_PTR_W:0]     count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = count_reg != FULL_COUNT;
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/btr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_back: drawing engine
// Owns font store and cursor, scans glyph rows and emits pixel writes.
// ----------------------------------------------------------------------------
module btr_back #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 8,
    parameter int GLYPH_COUNT  = 96
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [btr_pkg::COORD_W-1:0]       screen_width,
    input  logic [btr_pkg::ADDR_W-1:0]        frame_base,
    input  logic                              pop_valid,
    input  btr_pkg::item_t                    pop_item,
    output logic                              pop_ready,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [btr_pkg::COORD_W-1:0]       m_pixel_x,
    output logic [btr_pkg::COORD_W-1:0]       m_pixel_y,
    output logic [btr_pkg::ADDR_W-1:0]        m_pixel_address,
    output logic                              m_last_pixel,
    output btr_pkg::back_status_t             status
);

    localparam int FONT_DEPTH = GLYPH_COUNT * btr_pkg::ROWS_PER_SLOT;
    localparam int FONT_AW    = $clog2(FONT_DEPTH);
    localparam int GSLOT_W    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    localparam logic [btr_pkg::BITS_W-1:0] COL_MASK   = 8'((1 << GLYPH_WIDTH) - 1);
    localparam logic [btr_pkg::ROW_W-1:0]  LAST_ROW   = 3'(GLYPH_HEIGHT - 1);
    localparam logic [13:0]                COL_STEP   = 14'(GLYPH_WIDTH + btr_pkg::GAP);
    localparam logic [12:0]                LINE_STEP  = 13'(GLYPH_HEIGHT + btr_pkg::GAP);

    btr_pkg::back_state_t state_reg, state_next;

    // cursor state
    logic [btr_pkg::COORD_W-1:0]  col_reg, col_next;
    logic [btr_pkg::LINE_W-1:0]   line_reg, line_next;
    logic                         halted_reg, halted_next;

    // character being drawn
    logic [btr_pkg::SLOT_W-1:0]   glyph_reg;
    logic [btr_pkg::ORIGIN_W-1:0] ox_reg, oy_reg;
    logic [btr_pkg::ROW_W-1:0]    row_reg, row_next;
    logic [btr_pkg::COORD_W-1:0]  py_reg;
    logic [btr_pkg::PROD_W-1:0]   prod_reg;
    logic [btr_pkg::ADDR_W-1:0]   row_addr_reg;
    logic [btr_pkg::BITS_W-1:0]   rem_reg;

    // one pixel held back until it is known whether it is the last
    logic                         hold_valid_reg;
    logic [btr_pkg::COORD_W-1:0]  hold_x_reg, hold_y_reg;
    logic [btr_pkg::ADDR_W-1:0]   hold_addr_reg;

    // output register
    logic                         out_valid_reg;
    logic [btr_pkg::COORD_W-1:0]  out_x_reg, out_y_reg;
    logic [btr_pkg::ADDR_W-1:0]   out_addr_reg;
    logic                         out_last_reg;

    // font store ports
    logic                         font_we;
    logic                         font_re;
    logic [FONT_AW-1:0]           font_waddr;
    logic [FONT_AW-1:0]           font_raddr;
    logic [btr_pkg::BITS_W-1:0]   font_rdata;

    // control and datapath signals
    logic                         take_item;
    logic                         out_free;
    logic                         col_any;
    logic [btr_pkg::ROW_W-1:0]    col_j;
    logic [13:0]                  px;
    logic [13:0]                  py_sum;
    logic                         clip;
    logic [btr_pkg::ADDR_W-1:0]   pix_addr;
    logic                         emit_take;
    logic                         emit_push;
    logic                         flush_push;
    logic [btr_pkg::COORD_W-1:0]  eff_col;
    logic [btr_pkg::LINE_W-1:0]   eff_line;
    logic                         eff_halted;
    logic [13:0]                  col_sum;
    logic [12:0]                  line_sum;
    logic [btr_pkg::COORD_W-1:0]  col_adv;
    logic [btr_pkg::LINE_W-1:0]   line_adv;

    btr_ram #(
        .WIDTH (btr_pkg::BITS_W),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .aclk    (aclk),
        .wr_en   (font_we),
        .wr_addr (font_waddr),
        .wr_data (pop_item.bits),
        .rd_en   (font_re),
        .rd_addr (font_raddr),
        .rd_data (font_rdata)
    );

    assign font_waddr = FONT_AW'({pop_item.glyph[GSLOT_W-1:0], pop_item.row});
    assign font_raddr = FONT_AW'({glyph_reg[GSLOT_W-1:0], row_reg});

    // cursor as seen by the item at the queue head
    assign eff_col    = pop_item.first ? '0 : col_reg;
    assign eff_line   = pop_item.first ? '0 : line_reg;
    assign eff_halted = pop_item.first ? 1'b0 : halted_reg;

    // saturating cursor steps
    assign col_sum  = (take_item ? {1'b0, eff_col} : {1'b0, col_reg}) + COL_STEP;
    assign col_adv  = col_sum[13] ? '1 : col_sum[12:0];
    assign line_sum = {1'b0, eff_line} + LINE_STEP;
    assign line_adv = line_sum[12] ? '1 : line_sum[11:0];

    // lowest remaining set column
    always_comb begin
        col_j = '0;
        for (int k = btr_pkg::BITS_W - 1; k >= 0; k--) begin
            if (rem_reg[k]) begin
                col_j = 3'(k);
            end
        end
    end

    assign col_any  = |rem_reg;
    assign px       = 14'(ox_reg) + 14'(col_reg) + 14'(col_j);
    assign clip     = px >= {1'b0, screen_width};
    assign pix_addr = row_addr_reg + 32'({px[btr_pkg::COORD_W-1:0], 2'b00});
    assign py_sum   = 14'(oy_reg) + 14'(line_reg) + 14'(row_reg);
    assign out_free = !out_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            btr_pkg::ST_IDLE: begin
                if (pop_valid && pop_item.kind == btr_pkg::ITEM_GLYPH && !eff_halted) begin
                    state_next = btr_pkg::ST_ROW;
                end
            end
            btr_pkg::ST_ROW:   state_next = btr_pkg::ST_FETCH;
            btr_pkg::ST_FETCH: state_next = btr_pkg::ST_BASE;
            btr_pkg::ST_BASE:  state_next = btr_pkg::ST_COL;
            btr_pkg::ST_COL: begin
                if (!col_any) begin
                    state_next = (row_reg == LAST_ROW) ? btr_pkg::ST_FLUSH : btr_pkg::ST_ROW;
                end else if (clip) begin
                    state_next = btr_pkg::ST_FLUSH;
                end
            end
            btr_pkg::ST_FLUSH: begin
                if (!hold_valid_reg || out_free) begin
                    state_next = btr_pkg::ST_IDLE;
                end
            end
            default: state_next = btr_pkg::ST_IDLE;
        endcase
    end

    // control outputs and cursor updates
    always_comb begin
        pop_ready   = 1'b0;
        take_item   = 1'b0;
        font_we     = 1'b0;
        font_re     = 1'b0;
        emit_take   = 1'b0;
        emit_push   = 1'b0;
        flush_push  = 1'b0;
        col_next    = col_reg;
        line_next   = line_reg;
        halted_next = halted_reg;
        row_next    = row_reg;
        unique case (state_reg)
            btr_pkg::ST_IDLE: begin
                pop_ready = 1'b1;
                take_item = pop_valid;
                if (pop_valid) begin
                    case (pop_item.kind)
                        btr_pkg::ITEM_LOAD: begin
                            font_we = 1'b1;
                        end
                        btr_pkg::ITEM_NEWLINE: begin
                            halted_next = eff_halted;
                            col_next    = eff_halted ? eff_col : '0;
                            line_next   = eff_halted ? eff_line : line_adv;
                        end
                        btr_pkg::ITEM_BLANK: begin
                            halted_next = eff_halted;
                            col_next    = eff_halted ? eff_col : col_adv;
                            line_next   = eff_line;
                        end
                        btr_pkg::ITEM_GLYPH: begin
                            halted_next = eff_halted;
                            col_next    = eff_col;
                            line_next   = eff_line;
                            row_next    = '0;
                        end
                        default: ;
                    endcase
                end
            end
            btr_pkg::ST_ROW: begin
                font_re = 1'b1;
            end
            btr_pkg::ST_FETCH: ;
            btr_pkg::ST_BASE: ;
            btr_pkg::ST_COL: begin
                if (!col_any) begin
                    if (row_reg == LAST_ROW) begin
                        col_next = col_adv;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end else if (clip) begin
                    halted_next = 1'b1;
                end else if (!hold_valid_reg || out_free) begin
                    emit_take = 1'b1;
                    emit_push = hold_valid_reg;
                end
            end
            btr_pkg::ST_FLUSH: begin
                flush_push = hold_valid_reg && out_free;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= btr_pkg::ST_IDLE;
            col_reg        <= '0;
            line_reg       <= '0;
            halted_reg     <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            line_reg   <= line_next;
            halted_reg <= halted_next;
            if (emit_take) begin
                hold_valid_reg <= 1'b1;
            end else if (flush_push) begin
                hold_valid_reg <= 1'b0;
            end
            if (emit_push || flush_push) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // character latch and row setup
    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        if (take_item) begin
            glyph_reg <= pop_item.glyph;
            ox_reg    <= pop_item.origin_x;
            oy_reg    <= pop_item.origin_y;
        end
        if (state_reg == btr_pkg::ST_ROW) begin
            py_reg <= py_sum[btr_pkg::COORD_W-1:0];
        end
        if (state_reg == btr_pkg::ST_FETCH) begin
            rem_reg  <= font_rdata & COL_MASK;
            prod_reg <= py_reg * screen_width;
        end
        if (state_reg == btr_pkg::ST_BASE) begin
            row_addr_reg <= frame_base + 32'({prod_reg, 2'b00});
        end
        if (emit_take) begin
            rem_reg <= rem_reg & ~(8'b1 << col_j);
        end
    end

    // held pixel and output payload
    always_ff @(posedge aclk) begin
        if (emit_take) begin
            hold_x_reg    <= px[btr_pkg::COORD_W-1:0];
            hold_y_reg    <= py_reg;
            hold_addr_reg <= pix_addr;
        end
        if (emit_push || flush_push) begin
            out_x_reg    <= hold_x_reg;
            out_y_reg    <= hold_y_reg;
            out_addr_reg <= hold_addr_reg;
            out_last_reg <= flush_push;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_x       = out_x_reg;
    assign m_pixel_y       = out_y_reg;
    assign m_pixel_address = out_addr_reg;
    assign m_last_pixel    = out_last_reg;

    assign status.idle       = state_reg == btr_pkg::ST_IDLE;
    assign status.hold_valid = hold_valid_reg;
    assign status.halted     = halted_reg;

endmodule

/* rtl/bitmap_font_text_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_text_rasterizer: text to pixel-write converter
// Loads a 1-bit font and turns string characters into framebuffer writes.
// ----------------------------------------------------------------------------
//
//   channel  prefix  direction  carries
//   input    s_      in         font row load or one string character
//   result   m_      out        one pixel write (x, y, byte address, last)
//   config   cfg_    in         register index and write data
//
// Load, newline, blank and halted items are taken while the drawing engine
// stays idle. For a glyph, each row goes through a font store read, the row
// multiply, the row base add and a column scan that ends once no set column
// is left; the column scan emits one pixel per cycle while the output is not
// stalled. A clip ends the glyph early.
// Reset clears cursor, halt flag, queue and output; the font store is not
// cleared and holds whatever was last loaded.
// A stalled result holds one pixel in the output register and one in the
// engine; the two-entry queue keeps taking items meanwhile until it is full.
//
module bitmap_font_text_rasterizer #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 8,
    parameter int GLYPH_COUNT  = 96
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [6:0]                          s_glyph_index,
    input  logic [btr_pkg::ROW_W-1:0]           s_glyph_row,
    input  logic [btr_pkg::BITS_W-1:0]          s_glyph_row_bits,
    input  logic [btr_pkg::CODE_W-1:0]          s_char_code,
    input  logic [btr_pkg::ORIGIN_W-1:0]        s_origin_x,
    input  logic [btr_pkg::ORIGIN_W-1:0]        s_origin_y,
    input  logic                                s_first_of_string,
    // pixel writes
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [btr_pkg::COORD_W-1:0]         m_pixel_x,
    output logic [btr_pkg::COORD_W-1:0]         m_pixel_y,
    output logic [btr_pkg::ADDR_W-1:0]          m_pixel_address,
    output logic                                m_last_pixel
);

    logic [btr_pkg::COORD_W-1:0] screen_width_reg;
    logic [btr_pkg::ADDR_W-1:0]  frame_base_reg;

    logic                        push_valid;
    btr_pkg::item_t              push_item;
    logic                        push_ready;
    logic                        pop_valid;
    btr_pkg::item_t              pop_item;
    logic                        pop_ready;
    btr_pkg::back_status_t       bk_status;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg <= btr_pkg::SCREEN_WIDTH_RST;
            frame_base_reg   <= btr_pkg::FRAME_BASE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                btr_pkg::REG_SCREEN_WIDTH: screen_width_reg <= cfg_data[btr_pkg::COORD_W-1:0];
                btr_pkg::REG_FRAME_BASE:   frame_base_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // item decoder
    btr_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_glyph_index     (s_glyph_index),
        .s_glyph_row       (s_glyph_row),
        .s_glyph_row_bits  (s_glyph_row_bits),
        .s_char_code       (s_char_code),
        .s_origin_x        (s_origin_x),
        .s_origin_y        (s_origin_y),
        .s_first_of_string (s_first_of_string),
        .push_valid        (push_valid),
        .push_item         (push_item),
        .push_ready        (push_ready)
    );

    // item queue
    btr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // drawing engine
    btr_back #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_COUNT  (GLYPH_COUNT)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .screen_width    (screen_width_reg),
        .frame_base      (frame_base_reg),
        .pop_valid       (pop_valid),
        .pop_item        (pop_item),
        .pop_ready       (pop_ready),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_x       (m_pixel_x),
        .m_pixel_y       (m_pixel_y),
        .m_pixel_address (m_pixel_address),
        .m_last_pixel    (m_last_pixel),
        .status          (bk_status)
    );

    // queue only fills through an input transfer
    a_ready_falls_on_transfer: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid)
    ) else $error("input ready dropped without a transfer");

    // engine never goes idle with a pixel still held back
    a_idle_nothing_held: assert property (
        @(posedge aclk) disable iff (!aresetn)
        bk_status.idle |-> !bk_status.hold_valid
    ) else $error("engine idle with a held pixel");

    // a clip always goes through the flush step
    a_halt_flushes: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(bk_status.halted) |-> !bk_status.idle
    ) else $error("string halted without flushing");

    // results only appear while a glyph is being drawn
    a_result_from_scan: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(bk_status.idle)
    ) else $error("result raised by an idle engine");

endmodule

/* tb/btr_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btr_tb_pkg: pixel write tracker for the text rasterizer testbench
// Keeps a private copy of the font, cursor and registers, works out the pixel
// writes each accepted item causes and checks the block's writes in order.
// ----------------------------------------------------------------------------
package btr_tb_pkg;

    import btr_pkg::*;

    // font geometry, passed to the block as parameters
    localparam int GLYPH_W = 8;
    localparam int GLYPH_H = 8;
    localparam int GLYPH_N = 96;

    // saturation limits of cursor and line offset
    localparam int unsigned CURSOR_MAX = 8191;
    localparam int unsigned LINE_MAX   = 4095;
    localparam int unsigned COORD_MASK = 32'h1FFF;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ADDR_W-1:0]  addr;
        logic               last;
    } pixel_write_t;

    class pixel_write_tracker;

        logic [BITS_W-1:0]        font_rows [GLYPH_N*ROWS_PER_SLOT];
        logic [ROWS_PER_SLOT-1:0] rows_loaded [GLYPH_N];
        int unsigned              cursor_col;
        int unsigned              line_ofs;
        bit                       halted;
        logic [COORD_W-1:0]       screen_width;
        logic [ADDR_W-1:0]        frame_base;
        pixel_write_t             expected_writes [$];
        int                       errors;
        int                       checked;

        function new();
            foreach (rows_loaded[g]) rows_loaded[g] = '0;
            foreach (font_rows[k]) font_rows[k] = '0;
            cursor_col   = 0;
            line_ofs     = 0;
            halted       = 1'b0;
            screen_width = SCREEN_WIDTH_RST;
            frame_base   = FRAME_BASE_RST;
            errors       = 0;
            checked      = 0;
        endfunction

        function bit glyph_ready(int g);
            return &rows_loaded[g][GLYPH_H-1:0];
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SCREEN_WIDTH) begin
                screen_width = data[COORD_W-1:0];
            end else if (idx == REG_FRAME_BASE) begin
                frame_base = data;
            end
        endfunction

        // predict the pixel writes of one accepted input transfer
        function void note_item(logic op, logic [6:0] gidx, logic [ROW_W-1:0] grow,
                                logic [BITS_W-1:0] gbits, logic [CODE_W-1:0] code,
                                logic [ORIGIN_W-1:0] ox, logic [ORIGIN_W-1:0] oy,
                                logic first);
            int                glyph_no;
            int unsigned       px;
            int unsigned       py;
            int                emitted;
            bit                clipped;
            int                i;
            int                j;
            logic [BITS_W-1:0] bits;
            pixel_write_t      w;

            // font row load, glyphs past the font are dropped
            if (op == OP_LOAD) begin
                if (gidx < GLYPH_N) begin
                    font_rows[int'(gidx) * ROWS_PER_SLOT + int'(grow)] = gbits;
                    rows_loaded[gidx][grow] = 1'b1;
                end
                return;
            end

            if (first) begin
                cursor_col = 0;
                line_ofs   = 0;
                halted     = 1'b0;
            end
            if (halted) return;

            // newline: back to the origin column, one text line down
            if (code == NEWLINE_CODE) begin
                cursor_col = 0;
                line_ofs   = line_ofs + GLYPH_H + GAP;
                if (line_ofs > LINE_MAX) line_ofs = LINE_MAX;
                return;
            end

            // scan the glyph row by row, stop at the first clipped pixel
            emitted  = 0;
            clipped  = 1'b0;
            glyph_no = int'(code) - int'(FIRST_CODE);
            if (glyph_no >= 0 && glyph_no < GLYPH_N) begin
                for (i = 0; i < GLYPH_H && !clipped; i++) begin
                    bits = font_rows[glyph_no * ROWS_PER_SLOT + i];
                    for (j = 0; j < GLYPH_W && !clipped; j++) begin
                        if (bits[j]) begin
                            px = ox + cursor_col + j;
                            if (px >= screen_width) begin
                                halted  = 1'b1;
                                clipped = 1'b1;
                            end else begin
                                py     = (oy + line_ofs + i) & COORD_MASK;
                                w.x    = px[COORD_W-1:0];
                                w.y    = py[COORD_W-1:0];
                                w.addr = frame_base + 4 * (py * screen_width + px);
                                w.last = 1'b0;
                                expected_writes.push_back(w);
                                emitted++;
                            end
                        end
                    end
                end
                // flag the final write of this character
                if (emitted > 0) begin
                    w      = expected_writes.pop_back();
                    w.last = 1'b1;
                    expected_writes.push_back(w);
                end
                if (clipped) return;
            end

            cursor_col = cursor_col + GLYPH_W + GAP;
            if (cursor_col > CURSOR_MAX) cursor_col = CURSOR_MAX;
        endfunction

        // compare one result transfer with the oldest expected write
        function void check_pixel_write(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        logic [ADDR_W-1:0] addr, logic last);
            pixel_write_t w;

            checked++;
            if (expected_writes.size() == 0) begin
                $error("unexpected pixel write x=%0d y=%0d address=0x%08h", x, y, addr);
                errors++;
                return;
            end
            w = expected_writes.pop_front();
            if (x !== w.x) begin
                $error("pixel_x: expected %0d, got %0d", w.x, x);
                errors++;
            end
            if (y !== w.y) begin
                $error("pixel_y: expected %0d, got %0d", w.y, y);
                errors++;
            end
            if (addr !== w.addr) begin
                $error("pixel_address: expected 0x%08h, got 0x%08h", w.addr, addr);
                errors++;
            end
            if (last !== w.last) begin
                $error("last_pixel: expected %0d, got %0d", w.last, last);
                errors++;
            end
        endfunction

        function void flush_leftover();
            $error("%0d expected pixel writes never arrived", expected_writes.size());
            errors++;
            expected_writes.delete();
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the bitmap font text rasterizer
// Loads a font, draws directed and random strings under several screen width
// and frame base settings with random stalls on both channels, and checks
// every pixel write against the tracker's prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import btr_pkg::*;
    import btr_tb_pkg::*;

    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 200;
    localparam int SETUP_GLYPHS  = 6;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_operation;
    logic [6:0]            s_glyph_index;
    logic [ROW_W-1:0]      s_glyph_row;
    logic [BITS_W-1:0]     s_glyph_row_bits;
    logic [CODE_W-1:0]     s_char_code;
    logic [ORIGIN_W-1:0]   s_origin_x;
    logic [ORIGIN_W-1:0]   s_origin_y;
    logic                  s_first_of_string;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COORD_W-1:0]    m_pixel_x;
    logic [COORD_W-1:0]    m_pixel_y;
    logic [ADDR_W-1:0]     m_pixel_address;
    logic                  m_last_pixel;

    bit                    steady_run = 1'b0;
    int                    items_sent = 0;
    int                    settings   = 1;
    pixel_write_tracker    tracker;

    bitmap_font_text_rasterizer #(
        .GLYPH_WIDTH (GLYPH_W),
        .GLYPH_HEIGHT(GLYPH_H),
        .GLYPH_COUNT (GLYPH_N)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_glyph_index    (s_glyph_index),
        .s_glyph_row      (s_glyph_row),
        .s_glyph_row_bits (s_glyph_row_bits),
        .s_char_code      (s_char_code),
        .s_origin_x       (s_origin_x),
        .s_origin_y       (s_origin_y),
        .s_first_of_string(s_first_of_string),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_pixel_x        (m_pixel_x),
        .m_pixel_y        (m_pixel_y),
        .m_pixel_address  (m_pixel_address),
        .m_last_pixel     (m_last_pixel)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_ready <= steady_run || ($urandom_range(0, 99) >= 20);
    end

    // result transfer monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.check_pixel_write(m_pixel_x, m_pixel_y, m_pixel_address, m_last_pixel);
        end
    end

    // one input transfer, with an occasional idle gap in front
    task automatic send_item(logic op, logic [6:0] gidx, logic [ROW_W-1:0] grow,
                             logic [BITS_W-1:0] gbits, logic [CODE_W-1:0] code,
                             logic [ORIGIN_W-1:0] ox, logic [ORIGIN_W-1:0] oy,
                             logic first);
        if (!steady_run && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_operation       <= op;
        s_glyph_index     <= gidx;
        s_glyph_row       <= grow;
        s_glyph_row_bits  <= gbits;
        s_char_code       <= code;
        s_origin_x        <= ox;
        s_origin_y        <= oy;
        s_first_of_string <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_item(op, gidx, grow, gbits, code, ox, oy, first);
        items_sent++;
    endtask

    // fields that the operation ignores carry random values
    task automatic load_row(logic [6:0] gidx, logic [ROW_W-1:0] grow, logic [BITS_W-1:0] gbits);
        send_item(OP_LOAD, gidx, grow, gbits, CODE_W'($urandom), ORIGIN_W'($urandom),
                  ORIGIN_W'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic draw_char(logic [CODE_W-1:0] code, logic [ORIGIN_W-1:0] ox,
                             logic [ORIGIN_W-1:0] oy, logic first);
        send_item(OP_DRAW, 7'($urandom_range(0, 127)), ROW_W'($urandom), BITS_W'($urandom),
                  code, ox, oy, first);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold the sender until every expected write is in, then let the engine settle
    task automatic drain_results();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (tracker.pending() != 0) tracker.flush_leftover();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(int unsigned width, logic [ADDR_W-1:0] base);
        write_register(REG_SCREEN_WIDTH, CFG_DATA_W'(width));
        write_register(REG_FRAME_BASE, base);
        settings++;
    endtask

    // a code from a glyph whose rows are all loaded
    function automatic logic [CODE_W-1:0] glyph_code();
        int g;
        do begin
            g = $urandom_range(0, GLYPH_N - 1);
        end while (!tracker.glyph_ready(g));
        return CODE_W'(int'(FIRST_CODE) + g);
    endfunction

    // control or out-of-font code, never newline
    function automatic logic [CODE_W-1:0] blank_code();
        int c;
        do begin
            c = $urandom_range(0, 255);
        end while (c == int'(NEWLINE_CODE) ||
                   (c >= int'(FIRST_CODE) && c < int'(FIRST_CODE) + GLYPH_N));
        return CODE_W'(c);
    endfunction

    // any code, with font codes limited to loaded glyphs
    function automatic logic [CODE_W-1:0] noise_code();
        int c;
        c = $urandom_range(0, 255);
        if (c >= int'(FIRST_CODE) && c < int'(FIRST_CODE) + GLYPH_N &&
            !tracker.glyph_ready(c - int'(FIRST_CODE)))
            return glyph_code();
        return CODE_W'(c);
    endfunction

    function automatic logic [CODE_W-1:0] string_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return NEWLINE_CODE;
        if (r < 16) return blank_code();
        return glyph_code();
    endfunction

    // start column mostly well inside the screen so strings draw before clipping
    function automatic logic [ORIGIN_W-1:0] pick_origin_x();
        int w;
        w = int'(tracker.screen_width);
        if (w == 0 || $urandom_range(0, 9) == 0) return ORIGIN_W'($urandom);
        return ORIGIN_W'($urandom_range(0, (w > 60) ? w - 60 : 0));
    endfunction

    // mostly well formed strings, some row loads and loose characters
    task automatic random_traffic(int count);
        int                  sent_here;
        int                  len;
        int                  kind;
        int                  c;
        logic [ORIGIN_W-1:0] ox;
        logic [ORIGIN_W-1:0] oy;
        sent_here = 0;
        while (sent_here < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 3) begin
                drain_results();
            end else if (kind < 13) begin
                load_row(7'($urandom_range(0, 127)), ROW_W'($urandom), BITS_W'($urandom));
                sent_here++;
            end else if (kind < 25) begin
                draw_char(noise_code(), ORIGIN_W'($urandom), ORIGIN_W'($urandom),
                          1'($urandom_range(0, 1)));
                sent_here++;
            end else begin
                len = $urandom_range(2, 10);
                ox  = pick_origin_x();
                oy  = ORIGIN_W'($urandom);
                for (c = 0; c < len; c++) begin
                    draw_char(string_code(), ox, oy, c == 0);
                    sent_here++;
                end
            end
        end
    endtask

    // main sequence
    initial begin
        int g;
        int k;
        int r;
        logic [BITS_W-1:0] row_bits;

        tracker           = new();
        aresetn           <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        s_valid           <= 1'b0;
        s_operation       <= OP_LOAD;
        s_glyph_index     <= '0;
        s_glyph_row       <= '0;
        s_glyph_row_bits  <= '0;
        s_char_code       <= '0;
        s_origin_x        <= '0;
        s_origin_y        <= '0;
        s_first_of_string <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // font setup: full, empty and single-dot glyphs plus random ones
        for (k = 0; k < SETUP_GLYPHS; k++) begin
            case (k)
                0:       g = GLYPH_N - 1;
                1:       g = 1;
                2:       g = 2;
                3:       g = 0;
                default: g = $urandom_range(3, GLYPH_N - 2);
            endcase
            for (r = 0; r < ROWS_PER_SLOT; r++) begin
                case (g)
                    GLYPH_N - 1: row_bits = '1;
                    1:           row_bits = '0;
                    2:           row_bits = (r == 0) ? BITS_W'(1) : '0;
                    default:     row_bits = BITS_W'($urandom);
                endcase
                load_row(7'(g), ROW_W'(r), row_bits);
            end
        end

        // loads past the end of the font are dropped
        load_row(7'(GLYPH_N), 3'd0, 8'hFF);
        load_row(7'd127, 3'd7, 8'hFF);
        // full glyph, then space, empty glyph, control and out-of-font codes
        draw_char(8'h7F, 12'd0, 12'd0, 1'b1);
        draw_char(8'h20, 12'd0, 12'd0, 1'b0);
        draw_char(8'h21, 12'd0, 12'd0, 1'b0);
        draw_char(8'h00, 12'd0, 12'd0, 1'b0);
        draw_char(8'h1F, 12'd0, 12'd0, 1'b0);
        draw_char(8'h80, 12'd0, 12'd0, 1'b0);
        draw_char(8'hFF, 12'd0, 12'd0, 1'b0);
        // newline moves the next glyph one line down at the origin column
        draw_char(NEWLINE_CODE, 12'd0, 12'd0, 1'b0);
        draw_char(8'h7F, 12'd0, 12'd0, 1'b0);
        // right edge clip halts the string, newline and glyph ignored after it
        draw_char(8'h7F, 12'd788, 12'd20, 1'b1);
        draw_char(8'h7F, 12'd788, 12'd20, 1'b0);
        draw_char(NEWLINE_CODE, 12'd788, 12'd20, 1'b0);
        draw_char(8'h7F, 12'd788, 12'd20, 1'b0);
        // origin extremes: clip on the first pixel, bottom row without clip
        draw_char(8'h7F, 12'hFFF, 12'd5, 1'b1);
        draw_char(8'h7F, 12'd0, 12'hFFF, 1'b1);
        drain_results();

        // reset register values
        random_traffic(25);
        drain_results();

        // 4096 pixel wide screen, address wraps from the top, no idling on either side
        configure(4096, 32'hFFFF_FFFF);
        steady_run = 1'b1;
        random_traffic(25);
        drain_results();
        steady_run = 1'b0;

        // one pixel wide screen
        configure(1, ADDR_W'($urandom));
        draw_char(8'h22, 12'd0, 12'd100, 1'b1);
        draw_char(8'h22, 12'd0, 12'd100, 1'b0);
        random_traffic(10);
        drain_results();

        // zero width: every set pixel halts the string
        configure(0, 32'h0000_0000);
        random_traffic(10);
        drain_results();

        // random settings
        configure($urandom_range(1, 4096), ADDR_W'($urandom));
        random_traffic(20);
        drain_results();

        $display("covered %0d input items, %0d pixel writes, %0d register settings",
                 items_sent, tracker.checked, settings);
        $display("with clipping, halted strings, newlines and stalls on both sides");
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
